// ===== hdl/pstb_pkg.sv =====
// Package for the per-source token bucket limiter: request/result payloads,
// configuration register codes and the fixed constants of the refill math.
// No dependencies.
`timescale 1ns / 1ps

package pstb_pkg;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned RATE_W     = 30;
  localparam int unsigned ELAPSED_W  = 34;  // holds up to 10 s in ns
  localparam int unsigned QUOT_W     = 34;  // refill count before clamping

  localparam logic [RATE_W-1:0]    NS_PER_SEC     = 30'd1000000000;
  localparam logic [ELAPSED_W-1:0] MAX_ELAPSED_NS = 34'd10000000000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ENABLE = 2'd0,
    CFG_RATE   = 2'd1,
    CFG_BURST  = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic [31:0] source_addr;
    logic [63:0] now_ns;
  } req_t;

  typedef struct packed {
    logic        exceeded;
    logic [31:0] tokens_left;
  } res_t;

  typedef struct packed {
    logic              limiter_enabled;
    logic [RATE_W-1:0] refill_rate;
    logic [31:0]       burst_size;
  } cfg_t;

  // Request after classification, as handed from front end to bucket engine.
  typedef struct packed {
    req_t req;
    logic bypass;
  } job_t;

  // One bucket store row.
  typedef struct packed {
    logic        valid;
    logic [31:0] tag;
    logic [31:0] tokens;
    logic [63:0] last_time;
  } entry_t;

endpackage

// ===== hdl/pstb_fifo.sv =====
// Small register-based FIFO used between the limiter stages.
// Depends on nothing; payload is carried as a flat vector.
`timescale 1ns / 1ps

module pstb_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CNT_W'(DEPTH));
  assign empty_o = (count_q == '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// ===== hdl/pstb_front.sv =====
// Front end of the limiter: takes requests, marks bypass when limiting is off
// and maps the source address to its bucket slot (address mod NUM_BUCKETS).
// Depends on pstb_pkg.
`timescale 1ns / 1ps

module pstb_front #(
  parameter int unsigned NUM_BUCKETS = 1024
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           hold_i,
  input  logic                           enabled_i,
  input  logic                           push_i,
  input  pstb_pkg::req_t                 req_i,
  output logic                           full_o,
  output logic                           job_valid_o,
  output pstb_pkg::job_t                 job_o,
  output logic [$clog2(NUM_BUCKETS)-1:0] slot_o,
  input  logic                           job_ready_i
);

  localparam int unsigned IDX_W = $clog2(NUM_BUCKETS);
  // floor(a / N) == (a * RECIP) >> SHIFT, exact for every 32-bit a
  localparam int unsigned SHIFT       = 32 + IDX_W;
  localparam logic [64:0] RECIP_FULL  =
    ((65'd1 << SHIFT) + 65'(NUM_BUCKETS) - 65'd1) / 65'(NUM_BUCKETS);
  localparam logic [32:0] RECIP       = RECIP_FULL[32:0];

  logic           a_valid_q, a_valid_d, b_valid_q, b_valid_d;
  pstb_pkg::job_t a_job_q, b_job_q;
  logic [31:0]    a_quot_q;
  logic [IDX_W-1:0] b_slot_q;
  logic           advance, accept;
  logic [64:0]    recip_prod;
  logic [31:0]    quot_in, rem32;

  assign advance = !b_valid_q || job_ready_i;
  assign full_o  = hold_i || (a_valid_q && !advance);
  assign accept  = push_i && !full_o;

  assign recip_prod = 65'(req_i.source_addr) * 65'(RECIP);
  assign quot_in    = 32'(recip_prod >> SHIFT);
  assign rem32      = a_job_q.req.source_addr - 32'(64'(a_quot_q) * 64'(NUM_BUCKETS));

  assign a_valid_d = accept || (a_valid_q && !advance);
  assign b_valid_d = (a_valid_q && advance) || (b_valid_q && !job_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
      a_job_q   <= '0;
      a_quot_q  <= '0;
      b_job_q   <= '0;
      b_slot_q  <= '0;
    end else begin
      a_valid_q <= a_valid_d;
      b_valid_q <= b_valid_d;
      if (accept) begin
        a_job_q.req    <= req_i;
        a_job_q.bypass <= !enabled_i;
        a_quot_q       <= quot_in;
      end
      if (a_valid_q && advance) begin
        b_job_q  <= a_job_q;
        b_slot_q <= rem32[IDX_W-1:0];
      end
    end
  end

  assign job_valid_o = b_valid_q;
  assign job_o       = b_job_q;
  assign slot_o      = b_slot_q;

endmodule

// ===== hdl/pstb_engine.sv =====
// Bucket engine: owns the bucket store, runs one read-modify-write per limited
// request (lookup, elapsed time, refill multiply, divide by 1e9, clamp, take).
// Depends on pstb_pkg.
`timescale 1ns / 1ps

module pstb_engine #(
  parameter int unsigned NUM_BUCKETS = 1024
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  pstb_pkg::cfg_t                 cfg_i,
  input  logic                           job_empty_i,
  input  pstb_pkg::job_t                 job_i,
  input  logic [$clog2(NUM_BUCKETS)-1:0] slot_i,
  output logic                           job_pop_o,
  input  logic                           res_full_i,
  output logic                           res_push_o,
  output pstb_pkg::res_t                 res_o,
  output logic                           clearing_o
);

  localparam int unsigned IDX_W    = $clog2(NUM_BUCKETS);
  localparam int unsigned EW       = pstb_pkg::ELAPSED_W;
  localparam int unsigned QW       = pstb_pkg::QUOT_W;
  localparam int unsigned MAX_SECS = 10;  // whole seconds in the capped elapsed time
  // floor(2^60 / 1e9); estimate is at most two below the true quotient
  localparam logic [30:0] RECIP_NS   = 31'd1152921504;
  localparam logic [31:0] TWO_SEC_NS = 32'd2000000000;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_READ, ST_SPLIT, ST_MUL, ST_EST, ST_REM, ST_FIX, ST_FIN, ST_WRITE
  } state_e;

  state_e state_q;

  pstb_pkg::entry_t mem_q [NUM_BUCKETS];
  pstb_pkg::entry_t rd_q, mem_wd;
  logic             mem_we, mem_re;
  logic [IDX_W-1:0] mem_wa;

  logic [IDX_W-1:0] clr_q, slot_q;
  logic [31:0]      addr_q, base_tok_q, clamp_q;
  logic [63:0]      now_q;
  logic [EW-1:0]    elapsed_q;
  logic [3:0]       secs_q;
  logic [29:0]      frac_q;
  logic [59:0]      fprod_q;
  logic [QW-1:0]    whole_q;
  logic [30:0]      qest_q;
  logic [31:0]      rem_q;
  logic [QW-1:0]    dq_q;

  // Combinational helpers
  logic        hit, exceeded;
  logic [31:0] tok_sel, tok_left;
  logic [63:0] last_sel, diff;
  logic [3:0]  secs;
  logic [EW-1:0] secs_ns;
  logic [62:0] est;
  logic [60:0] qd;
  logic [59:0] rem_full;
  logic [1:0]  fix;
  logic [34:0] sum;

  function automatic logic [3:0] whole_secs(logic [EW-1:0] e);
    logic [3:0] s;
    s = '0;
    for (int k = 1; k <= MAX_SECS; k++) begin
      if (e >= EW'(k) * EW'(pstb_pkg::NS_PER_SEC)) begin
        s = 4'(k);
      end
    end
    return s;
  endfunction

  assign hit      = rd_q.valid && (rd_q.tag == addr_q);
  assign tok_sel  = hit ? rd_q.tokens : cfg_i.burst_size;
  assign last_sel = hit ? rd_q.last_time : now_q;
  assign diff     = (now_q > last_sel) ? now_q - last_sel : 64'd0;

  // refill = secs * rate + floor(frac * rate / 1e9), frac below one second
  assign secs     = whole_secs(elapsed_q);
  assign secs_ns  = EW'(secs) * EW'(pstb_pkg::NS_PER_SEC);
  assign est      = 63'(fprod_q[59:28]) * 63'(RECIP_NS);
  assign qd       = 61'(qest_q) * 61'(pstb_pkg::NS_PER_SEC);
  assign rem_full = fprod_q - qd[59:0];
  assign fix      = (rem_q >= TWO_SEC_NS) ? 2'd2 :
                    (rem_q >= 32'(pstb_pkg::NS_PER_SEC)) ? 2'd1 : 2'd0;
  assign sum      = 35'(base_tok_q) + 35'(dq_q);

  assign exceeded = (clamp_q == 32'd0);
  assign tok_left = exceeded ? 32'd0 : clamp_q - 32'd1;

  // A bypassed request answers straight from idle; a lookup answers at write.
  assign job_pop_o  = (state_q == ST_IDLE) && !job_empty_i && (!job_i.bypass || !res_full_i);
  assign mem_re     = job_pop_o && !job_i.bypass;
  assign res_push_o = (job_pop_o && job_i.bypass) || ((state_q == ST_WRITE) && !res_full_i);
  assign clearing_o = (state_q == ST_CLEAR);

  always_comb begin
    res_o = '0;
    if (state_q == ST_WRITE) begin
      res_o.exceeded    = exceeded;
      res_o.tokens_left = tok_left;
    end
  end

  always_comb begin
    mem_we = 1'b0;
    mem_wa = clr_q;
    mem_wd = '0;
    if (state_q == ST_CLEAR) begin
      mem_we = 1'b1;
    end else if ((state_q == ST_WRITE) && !res_full_i) begin
      mem_we           = 1'b1;
      mem_wa           = slot_q;
      mem_wd.valid     = 1'b1;
      mem_wd.tag       = addr_q;
      mem_wd.tokens    = tok_left;
      mem_wd.last_time = now_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rd_q <= mem_q[slot_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_CLEAR;
      clr_q      <= '0;
      slot_q     <= '0;
      addr_q     <= '0;
      now_q      <= '0;
      base_tok_q <= '0;
      elapsed_q  <= '0;
      secs_q     <= '0;
      frac_q     <= '0;
      fprod_q    <= '0;
      whole_q    <= '0;
      qest_q     <= '0;
      rem_q      <= '0;
      dq_q       <= '0;
      clamp_q    <= '0;
    end else begin
      unique case (state_q)
        ST_CLEAR: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == IDX_W'(NUM_BUCKETS - 1)) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (mem_re) begin
            addr_q  <= job_i.req.source_addr;
            now_q   <= job_i.req.now_ns;
            slot_q  <= slot_i;
            state_q <= ST_READ;
          end
        end
        ST_READ: begin
          base_tok_q <= tok_sel;
          elapsed_q  <= (diff > 64'(pstb_pkg::MAX_ELAPSED_NS)) ?
                        pstb_pkg::MAX_ELAPSED_NS : diff[EW-1:0];
          state_q    <= ST_SPLIT;
        end
        ST_SPLIT: begin
          secs_q  <= secs;
          frac_q  <= 30'(elapsed_q - secs_ns);
          state_q <= ST_MUL;
        end
        ST_MUL: begin
          fprod_q <= 60'(frac_q) * 60'(cfg_i.refill_rate);
          whole_q <= QW'(secs_q) * QW'(cfg_i.refill_rate);
          state_q <= ST_EST;
        end
        ST_EST: begin
          qest_q  <= est[62:32];
          state_q <= ST_REM;
        end
        ST_REM: begin
          // remainder stays below 3e9
          rem_q   <= rem_full[31:0];
          state_q <= ST_FIX;
        end
        ST_FIX: begin
          dq_q    <= whole_q + QW'(qest_q) + QW'(fix);
          state_q <= ST_FIN;
        end
        ST_FIN: begin
          clamp_q <= (sum > 35'(cfg_i.burst_size)) ? cfg_i.burst_size : sum[31:0];
          state_q <= ST_WRITE;
        end
        ST_WRITE: begin
          if (!res_full_i) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== hdl/per_source_token_bucket_limiter_core.sv =====
// Top level of the per-source token bucket limiter: configuration registers,
// front end, job queue, bucket engine and result queue.
// Depends on pstb_pkg, pstb_fifo, pstb_front and pstb_engine.
`timescale 1ns / 1ps

// A request with limiting on occupies the bucket engine through store read,
// elapsed time, whole-second split, refill multiplies, reciprocal estimate of
// the divide by 1e9, remainder, correction, clamp and store write; the engine
// takes no new request before the write, which waits on a full result queue.
// With limiting off a request is answered from idle. The front end maps the
// address to a slot in a two-stage pipeline and queues up to two requests
// ahead of the engine, and up to two results wait for pop. After reset, full
// stays high while the bucket store is cleared; configuration writes are
// taken during that time. Configure only while no request is in flight.

module per_source_token_bucket_limiter_core #(
  parameter int unsigned NUM_BUCKETS = 1024
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 push,
  input  pstb_pkg::req_t                       req_i,
  output logic                                 full,
  input  logic                                 pop,
  output pstb_pkg::res_t                       res_o,
  output logic                                 empty,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [pstb_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [pstb_pkg::CFG_DATA_W-1:0]      cfg_data_i
);

  localparam int unsigned IDX_W = $clog2(NUM_BUCKETS);
  localparam int unsigned JOB_W = $bits(pstb_pkg::job_t) + IDX_W;
  localparam int unsigned RES_W = $bits(pstb_pkg::res_t);

  pstb_pkg::cfg_t   cfg_q;
  pstb_pkg::job_t   front_job, eng_job;
  logic [IDX_W-1:0] front_slot, eng_slot;
  logic             front_valid, jq_full, jq_empty, jq_pop, clearing;
  logic             res_push, rq_full;
  pstb_pkg::res_t   eng_res;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (pstb_pkg::cfg_reg_e'(cfg_index_i))
        pstb_pkg::CFG_ENABLE: cfg_q.limiter_enabled <= cfg_data_i[0];
        pstb_pkg::CFG_RATE:   cfg_q.refill_rate     <= cfg_data_i[pstb_pkg::RATE_W-1:0];
        pstb_pkg::CFG_BURST:  cfg_q.burst_size      <= cfg_data_i;
        default: ;
      endcase
    end
  end

  pstb_front #(
    .NUM_BUCKETS(NUM_BUCKETS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .hold_i     (clearing),
    .enabled_i  (cfg_q.limiter_enabled),
    .push_i     (push),
    .req_i      (req_i),
    .full_o     (full),
    .job_valid_o(front_valid),
    .job_o      (front_job),
    .slot_o     (front_slot),
    .job_ready_i(!jq_full)
  );

  pstb_fifo #(
    .WIDTH(JOB_W),
    .DEPTH(2)
  ) u_job_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (front_valid),
    .data_i ({front_job, front_slot}),
    .full_o (jq_full),
    .pop_i  (jq_pop),
    .data_o ({eng_job, eng_slot}),
    .empty_o(jq_empty)
  );

  pstb_engine #(
    .NUM_BUCKETS(NUM_BUCKETS)
  ) u_engine (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .job_empty_i(jq_empty),
    .job_i      (eng_job),
    .slot_i     (eng_slot),
    .job_pop_o  (jq_pop),
    .res_full_i (rq_full),
    .res_push_o (res_push),
    .res_o      (eng_res),
    .clearing_o (clearing)
  );

  pstb_fifo #(
    .WIDTH(RES_W),
    .DEPTH(2)
  ) u_res_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (res_push),
    .data_i (eng_res),
    .full_o (rq_full),
    .pop_i  (pop),
    .data_o (res_o),
    .empty_o(empty)
  );

endmodule

// ===== hdl/pstb_checker.sv =====
// Port-level checker for the token bucket limiter, bound to the top level.
// Depends on pstb_pkg and per_source_token_bucket_limiter_core.
`timescale 1ns / 1ps

module pstb_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            push,
  input pstb_pkg::req_t                  req_i,
  input logic                            full,
  input logic                            pop,
  input pstb_pkg::res_t                  res_o,
  input logic                            empty,
  input logic                            cfg_valid_i,
  input logic                            cfg_ready_o,
  input logic [pstb_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input logic [pstb_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  logic [3:0] pending_q;
  logic       enabled_q;
  logic       in_acc, out_acc;

  assign in_acc  = push && !full;
  assign out_acc = pop && !empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
      enabled_q <= 1'b0;
    end else begin
      pending_q <= pending_q + 4'(in_acc) - 4'(out_acc);
      if (cfg_valid_i && cfg_ready_o && (cfg_index_i == pstb_pkg::CFG_ENABLE)) begin
        enabled_q <= cfg_data_i[0];
      end
    end
  end

  // every result shown belongs to a request taken earlier
  a_no_orphan_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (pending_q != 4'd0))
    else $error("result shown with no request outstanding");

  a_result_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(res_o)))
    else $error("waiting result changed or vanished");

  a_exceeded_empty_bucket: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && res_o.exceeded) |-> (res_o.tokens_left == 32'd0))
    else $error("exceeded request reports tokens left");

  a_disabled_passes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !enabled_q) |-> (!res_o.exceeded && (res_o.tokens_left == 32'd0)))
    else $error("request limited while limiter disabled");

endmodule

bind per_source_token_bucket_limiter_core pstb_checker u_pstb_checker (.*);
